[rtl/dhd_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the directed Hausdorff distance block.
// No dependencies; all other files but dhd_ref_store refer to it by scoped names.
package dhd_pkg;

  localparam int WORST_W = 33;
  localparam int DEV_W   = 17;

  localparam logic [WORST_W-1:0] WORST_MAX = {WORST_W{1'b1}};
  localparam logic [DEV_W-1:0]   DEV_SAT   = 17'd92682;

  typedef enum logic [1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_ADD   = 2'd1,
    FUNC_CAND  = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SQRT,
    ST_EMIT
  } state_t;

  // Tag that travels with each store read down the distance pipeline.
  typedef struct packed {
    logic valid;
    logic first;
    logic final_elem;
  } tap_t;

endpackage

[rtl/dhd_ref_store.sv]
`timescale 1ns / 1ps
// Reference point store: one write port, one read port, registered read data.
// No dependencies.
module dhd_ref_store #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/dhd_nearest.sv]
`timescale 1ns / 1ps
// Distance pipeline: abs difference, square, sum and running minimum over one scan.
// Depends on dhd_pkg (tap_t).
module dhd_nearest #(
  parameter int COORD_WIDTH = 16,
  parameter int SUM_W       = 2 * COORD_WIDTH + 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dhd_pkg::tap_t                 tap_in,
  input  logic signed [COORD_WIDTH-1:0] px,
  input  logic signed [COORD_WIDTH-1:0] py,
  input  logic signed [COORD_WIDTH-1:0] ref_x,
  input  logic signed [COORD_WIDTH-1:0] ref_y,
  output logic                          done,
  output logic [SUM_W-1:0]              nearest
);

  localparam int SQ_W = 2 * COORD_WIDTH;

  dhd_pkg::tap_t tap_a_r, tap_b_r, tap_c_r;
  logic [COORD_WIDTH-1:0] dx_r, dy_r;
  logic [SQ_W-1:0]        sqx_r, sqy_r;
  logic [SUM_W-1:0]       min_r, sum;
  logic                   done_r;
  logic signed [COORD_WIDTH:0] diff_x, diff_y, abs_x, abs_y;

  always_comb begin
    diff_x = {px[COORD_WIDTH-1], px} - {ref_x[COORD_WIDTH-1], ref_x};
    diff_y = {py[COORD_WIDTH-1], py} - {ref_y[COORD_WIDTH-1], ref_y};
    abs_x  = diff_x[COORD_WIDTH] ? -diff_x : diff_x;
    abs_y  = diff_y[COORD_WIDTH] ? -diff_y : diff_y;
    sum    = SUM_W'(sqx_r) + SUM_W'(sqy_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_a_r <= '0;
      tap_b_r <= '0;
      tap_c_r <= '0;
      done_r  <= 1'b0;
    end else begin
      tap_a_r <= tap_in;
      tap_b_r <= tap_a_r;
      tap_c_r <= tap_b_r;
      done_r  <= tap_c_r.valid & tap_c_r.final_elem;
    end
  end

  always_ff @(posedge clk) begin
    dx_r  <= abs_x[COORD_WIDTH-1:0];
    dy_r  <= abs_y[COORD_WIDTH-1:0];
    sqx_r <= dx_r * dx_r;
    sqy_r <= dy_r * dy_r;
    if (tap_c_r.valid && (tap_c_r.first || sum < min_r)) begin
      min_r <= sum;
    end
  end

  assign done    = done_r;
  assign nearest = min_r;

endmodule

[rtl/dhd_sqrt.sv]
`timescale 1ns / 1ps
// Iterative floor square root, one result bit per cycle (restoring method).
// Depends on dhd_pkg (WORST_W, DEV_W).
module dhd_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [dhd_pkg::WORST_W-1:0] value,
  output logic                        done,
  output logic [dhd_pkg::DEV_W-1:0]   root
);

  localparam int RW  = dhd_pkg::DEV_W;
  localparam int RAD = 2 * RW;
  localparam int REM = RW + 3;
  localparam int IW  = $clog2(RW);

  logic [RAD-1:0] rad_r;
  logic [REM-1:0] rem_r, rem_sh, trial;
  logic [RW-1:0]  root_r;
  logic [IW-1:0]  iter_r;
  logic           busy_r, done_r;

  always_comb begin
    rem_sh = {rem_r[RW:0], rad_r[RAD-1 -: 2]};
    trial  = REM'({root_r, 2'b01});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && iter_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= RAD'(value);
      rem_r  <= '0;
      root_r <= '0;
      iter_r <= IW'(RW - 1);
    end else if (busy_r) begin
      rad_r  <= {rad_r[RAD-3:0], 2'b00};
      iter_r <= iter_r - 1'b1;
      if (rem_sh >= trial) begin
        rem_r  <= rem_sh - trial;
        root_r <= {root_r[RW-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        root_r <= {root_r[RW-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

[rtl/directed_hausdorff_distance.sv]
`timescale 1ns / 1ps
// Directed Hausdorff distance from a candidate path to a stored reference set.
// Clear and add items are taken in IDLE and leave it there; a candidate scans the N stored points
// (one store read per cycle through a 4-stage distance pipeline) and needs no scan with an empty store.
// A last point then runs 17 root steps, the done strobe and one output load (only the output load
// with an empty store). Reset (synchronous, rst_n low) empties the store and clears the
// running maximum; store contents are left as they are and never read before being written.
module directed_hausdorff_distance #(
  parameter int REF_DEPTH   = 4096,
  parameter int COORD_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_func,
  input  logic signed [COORD_WIDTH-1:0]  in_point_x,
  input  logic signed [COORD_WIDTH-1:0]  in_point_y,
  input  logic                           in_last,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [dhd_pkg::DEV_W-1:0]      out_deviation,
  output logic                           out_no_reference
);

  localparam int AW    = (REF_DEPTH > 1) ? $clog2(REF_DEPTH) : 1;
  localparam int CNT_W = $clog2(REF_DEPTH + 1);
  localparam int SUM_W = 2 * COORD_WIDTH + 1;
  localparam int WW    = dhd_pkg::WORST_W;
  localparam int EXT_W = (SUM_W > WW) ? SUM_W : WW;

  dhd_pkg::state_t state_r, state_nxt;
  dhd_pkg::tap_t   tap_in;

  logic [CNT_W-1:0] count_r, issue_r;
  logic signed [COORD_WIDTH-1:0] px_r, py_r;
  logic             last_r;
  logic [WW-1:0]    worst_r, worst_upd, near_sat;
  logic [EXT_W-1:0] near_ext;
  logic [dhd_pkg::DEV_W-1:0] dev_pend_r, root;
  logic             noref_pend_r;
  logic             out_valid_r, out_load;
  logic [dhd_pkg::DEV_W-1:0] out_dev_r;
  logic             out_noref_r;

  logic             accept, full, wr_en, rd_en, near_done, sqrt_start, sqrt_done;
  logic             go_scan, go_noref, do_clear;
  logic [2*COORD_WIDTH-1:0] rd_data;
  logic [SUM_W-1:0] nearest;

  assign accept = in_valid && !in_stall;
  assign full   = (count_r == CNT_W'(REF_DEPTH));
  assign rd_en  = (state_r == dhd_pkg::ST_SCAN) && (issue_r < count_r);

  assign tap_in.valid      = rd_en;
  assign tap_in.first      = (issue_r == '0);
  assign tap_in.final_elem = (issue_r == count_r - 1'b1);

  // Clamp the scan minimum into the running maximum's width, then take the max.
  always_comb begin
    near_ext  = EXT_W'(nearest);
    near_sat  = (near_ext > EXT_W'(dhd_pkg::WORST_MAX)) ? dhd_pkg::WORST_MAX
                                                         : near_ext[WW-1:0];
    worst_upd = (near_sat > worst_r) ? near_sat : worst_r;
  end

  always_comb begin
    state_nxt  = state_r;
    in_stall   = (state_r != dhd_pkg::ST_IDLE);
    wr_en      = 1'b0;
    do_clear   = 1'b0;
    go_scan    = 1'b0;
    go_noref   = 1'b0;
    sqrt_start = 1'b0;
    out_load   = 1'b0;
    case (state_r)
      dhd_pkg::ST_IDLE: begin
        if (accept) begin
          case (dhd_pkg::func_t'(in_func))
            dhd_pkg::FUNC_CLEAR: do_clear = 1'b1;
            dhd_pkg::FUNC_ADD:   wr_en = !full;
            dhd_pkg::FUNC_CAND: begin
              if (count_r != '0) begin
                go_scan   = 1'b1;
                state_nxt = dhd_pkg::ST_SCAN;
              end else if (in_last) begin
                go_noref  = 1'b1;
                state_nxt = dhd_pkg::ST_EMIT;
              end
            end
            default: ;
          endcase
        end
      end
      dhd_pkg::ST_SCAN: begin
        if (near_done) begin
          sqrt_start = last_r;
          state_nxt  = last_r ? dhd_pkg::ST_SQRT : dhd_pkg::ST_IDLE;
        end
      end
      dhd_pkg::ST_SQRT: begin
        if (sqrt_done) begin
          state_nxt = dhd_pkg::ST_EMIT;
        end
      end
      dhd_pkg::ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = dhd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = dhd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dhd_pkg::ST_IDLE;
      count_r     <= '0;
      worst_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (do_clear) begin
        count_r <= '0;
      end else if (wr_en) begin
        count_r <= count_r + 1'b1;
      end
      if (out_load) begin
        worst_r <= '0;
      end else if (state_r == dhd_pkg::ST_SCAN && near_done) begin
        worst_r <= worst_upd;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go_scan) begin
      px_r    <= in_point_x;
      py_r    <= in_point_y;
      last_r  <= in_last;
      issue_r <= '0;
    end else if (rd_en) begin
      issue_r <= issue_r + 1'b1;
    end
    if (go_noref) begin
      dev_pend_r   <= dhd_pkg::DEV_SAT;
      noref_pend_r <= 1'b1;
    end else if (sqrt_done) begin
      dev_pend_r   <= (root > dhd_pkg::DEV_SAT) ? dhd_pkg::DEV_SAT : root;
      noref_pend_r <= 1'b0;
    end
    if (out_load) begin
      out_dev_r   <= dev_pend_r;
      out_noref_r <= noref_pend_r;
    end
  end

  dhd_ref_store #(
    .DEPTH (REF_DEPTH),
    .AW    (AW),
    .DW    (2 * COORD_WIDTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[AW-1:0]),
    .wr_data ({in_point_x, in_point_y}),
    .rd_en   (rd_en),
    .rd_addr (issue_r[AW-1:0]),
    .rd_data (rd_data)
  );

  dhd_nearest #(
    .COORD_WIDTH (COORD_WIDTH),
    .SUM_W       (SUM_W)
  ) u_nearest (
    .clk     (clk),
    .rst_n   (rst_n),
    .tap_in  (tap_in),
    .px      (px_r),
    .py      (py_r),
    .ref_x   (rd_data[2*COORD_WIDTH-1:COORD_WIDTH]),
    .ref_y   (rd_data[COORD_WIDTH-1:0]),
    .done    (near_done),
    .nearest (nearest)
  );

  dhd_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .value (worst_upd),
    .done  (sqrt_done),
    .root  (root)
  );

  assign out_valid        = out_valid_r;
  assign out_deviation    = out_dev_r;
  assign out_no_reference = out_noref_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(REF_DEPTH))
    else $error("reference count beyond store depth");

  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> issue_r < count_r && state_r == dhd_pkg::ST_SCAN)
    else $error("store read outside the filled range");

  a_done_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    near_done |-> state_r == dhd_pkg::ST_SCAN)
    else $error("scan result outside a scan");

  a_noref_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_no_reference |-> out_deviation == dhd_pkg::DEV_SAT)
    else $error("empty store result not saturated");

  a_sqrt_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    sqrt_start |-> last_r)
    else $error("square root started on a non-final point");

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for directed_hausdorff_distance: a deviation tracker class
// predicts each path result; a task drives the input channel and a process the output stall.
// Depends on dhd_pkg and the directed_hausdorff_distance RTL.
module tb;

  localparam int STORE_DEPTH = 4096;
  localparam int HOLD_CYCLES = 300;
  localparam logic [1:0] FUNC_NOP = 2'd3;  // unused selector

  typedef struct {
    logic [dhd_pkg::DEV_W-1:0] deviation;
    logic                      no_reference;
  } path_result_t;

  // Keeps its own copy of the reference store and the running worst distance.
  class deviation_tracker;
    longint       ref_x[STORE_DEPTH];
    longint       ref_y[STORE_DEPTH];
    int unsigned  stored;
    logic [63:0]  worst;
    path_result_t awaited[$];
    int           errors;
    int           produced;

    function new();
      stored   = 0;
      worst    = '0;
      errors   = 0;
      produced = 0;
    endfunction

    function logic [dhd_pkg::DEV_W-1:0] floor_root(logic [63:0] v);
      logic [dhd_pkg::DEV_W-1:0] r;
      logic [63:0]               t;
      r = '0;
      for (int b = dhd_pkg::DEV_W - 1; b >= 0; b--) begin
        t = 64'(r | (17'd1 << b));
        if (t * t <= v) r = r | (17'd1 << b);
      end
      return r;
    endfunction

    function logic [63:0] nearest_squared(longint px, longint py);
      logic [63:0] best;
      longint      dx, dy;
      logic [63:0] d;
      best = '1;
      for (int i = 0; i < stored; i++) begin
        dx = px - ref_x[i];
        dy = py - ref_y[i];
        d  = 64'(dx * dx + dy * dy);
        if (d < best) best = d;
      end
      if (best > 64'(dhd_pkg::WORST_MAX)) best = 64'(dhd_pkg::WORST_MAX);
      return best;
    endfunction

    function void note_item(logic [1:0] func, logic signed [15:0] x,
                            logic signed [15:0] y, logic last);
      path_result_t res;
      logic [63:0]  near;
      logic [dhd_pkg::DEV_W-1:0] root;
      case (func)
        dhd_pkg::FUNC_CLEAR: stored = 0;
        dhd_pkg::FUNC_ADD: begin
          if (stored < STORE_DEPTH) begin
            ref_x[stored] = longint'(x);
            ref_y[stored] = longint'(y);
            stored++;
          end
        end
        dhd_pkg::FUNC_CAND: begin
          if (stored > 0) begin
            near = nearest_squared(longint'(x), longint'(y));
            if (near > worst) worst = near;
          end
          if (last) begin
            if (stored == 0) begin
              res.deviation    = dhd_pkg::DEV_SAT;
              res.no_reference = 1'b1;
            end else begin
              root = floor_root(worst);
              res.deviation    = (root > dhd_pkg::DEV_SAT) ? dhd_pkg::DEV_SAT : root;
              res.no_reference = 1'b0;
            end
            worst = '0;
            awaited.insert(awaited.size(), res);
            produced++;
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [dhd_pkg::DEV_W-1:0] deviation, logic no_reference);
      path_result_t exp_res;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result deviation=%0d no_reference=%0b",
                 $time, deviation, no_reference);
        errors++;
        return;
      end
      exp_res = awaited.pop_front();
      if (deviation !== exp_res.deviation) begin
        $display("%0t: deviation mismatch expected=%0d actual=%0d",
                 $time, exp_res.deviation, deviation);
        errors++;
      end
      if (no_reference !== exp_res.no_reference) begin
        $display("%0t: no_reference mismatch expected=%0b actual=%0b",
                 $time, exp_res.no_reference, no_reference);
        errors++;
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic [1:0]                in_func;
  logic signed [15:0]        in_point_x;
  logic signed [15:0]        in_point_y;
  logic                      in_last;
  logic                      out_valid;
  logic                      out_stall;
  logic [dhd_pkg::DEV_W-1:0] out_deviation;
  logic                      out_no_reference;

  deviation_tracker tracker;
  bit hold_req;
  int work_items;
  int tx_quiet;

  directed_hausdorff_distance dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_point_x       (in_point_x),
    .in_point_y       (in_point_y),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_deviation    (out_deviation),
    .out_no_reference (out_no_reference)
  );

  initial begin
    clk        = 1'b0;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_func    = dhd_pkg::FUNC_CLEAR;
    in_point_x = '0;
    in_point_y = '0;
    in_last    = 1'b0;
    out_stall  = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  // Result channel: short random stalls, occasional long ones, quiet stretches,
  // and one long hold-off on request.
  initial begin
    int stall_left;
    int quiet_left;
    int r;
    stall_left = 0;
    quiet_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (quiet_left > 0) begin
          quiet_left--;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 15) stall_left = $urandom_range(1, 3);
          else if (r < 18) stall_left = $urandom_range(20, 80);
          else if (r < 20) quiet_left = $urandom_range(50, 200);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      tracker.check_result(out_deviation, out_no_reference);
  end

  function automatic int next_gap();
    int r;
    if (tx_quiet > 0) begin
      tx_quiet--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) tx_quiet = $urandom_range(10, 30);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_item(input logic [1:0] func, input logic signed [15:0] x,
                           input logic signed [15:0] y, input logic last,
                           input int gap);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    in_func    <= func;
    in_point_x <= x;
    in_point_y <= y;
    in_last    <= last;
    do @(posedge clk); while (in_stall);
    tracker.note_item(func, x, y, last);
    if (func != FUNC_NOP) work_items++;
  endtask

  function automatic logic signed [15:0] rand_coord();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return 16'sh8000;
    if (r < 8) return 16'sh7fff;
    if (r < 10) return 16'sh0000;
    if (r < 12) return 16'shffff;
    return 16'($urandom);
  endfunction

  function automatic logic signed [15:0] near_coord(logic signed [15:0] c);
    return 16'(c + $signed($urandom_range(0, 4095)) - 2048);
  endfunction

  initial begin
    logic signed [15:0] cx, cy;
    int k, r;
    tracker    = new();
    work_items = 0;
    tx_quiet   = 0;
    hold_req   = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Empty store, ignored selector and ignored last bits, coordinate extremes.
    send_item(dhd_pkg::FUNC_CAND, 16'sd100, -16'sd100, 1'b0, 0);
    send_item(dhd_pkg::FUNC_CAND, 16'sd0, 16'sd0, 1'b1, 0);
    send_item(FUNC_NOP, 16'sh7fff, 16'sh8000, 1'b1, 0);
    send_item(dhd_pkg::FUNC_ADD, 16'sh8000, 16'sh8000, 1'b1, 0);
    send_item(dhd_pkg::FUNC_ADD, 16'sh7fff, 16'sh7fff, 1'b0, 1);
    send_item(dhd_pkg::FUNC_CAND, 16'sh7fff, 16'sh8000, 1'b0, 0);
    send_item(dhd_pkg::FUNC_CAND, 16'sd0, 16'sd0, 1'b1, 0);
    send_item(dhd_pkg::FUNC_CAND, 16'sh8000, 16'sh7fff, 1'b1, 2);
    send_item(dhd_pkg::FUNC_CLEAR, 16'sh7fff, 16'sh7fff, 1'b1, 0);
    send_item(dhd_pkg::FUNC_CAND, 16'sd5, 16'sd5, 1'b1, 0);
    // Clear mid-path then last point with an empty store: worst is dropped.
    send_item(dhd_pkg::FUNC_ADD, 16'sd256, 16'sd256, 1'b0, 0);
    send_item(dhd_pkg::FUNC_CAND, 16'sh8000, 16'sh8000, 1'b0, 0);
    send_item(dhd_pkg::FUNC_CLEAR, 16'sd0, 16'sd0, 1'b0, 0);
    send_item(dhd_pkg::FUNC_CAND, 16'sd1, 16'sd1, 1'b1, 0);
    // Clear mid-path with a refill: the earlier worst carries over.
    send_item(dhd_pkg::FUNC_ADD, 16'sd0, 16'sd0, 1'b0, 0);
    send_item(dhd_pkg::FUNC_CAND, 16'sh8000, 16'sh8000, 1'b0, 0);
    send_item(dhd_pkg::FUNC_CLEAR, 16'sd0, 16'sd0, 1'b0, 0);
    send_item(dhd_pkg::FUNC_ADD, 16'sd256, 16'sd0, 1'b0, 0);
    send_item(dhd_pkg::FUNC_CAND, 16'sd256, 16'sd0, 1'b1, 0);
    send_item(dhd_pkg::FUNC_ADD, 16'shffff, 16'shffff, 1'b0, 3);
    send_item(dhd_pkg::FUNC_CAND, 16'shffff, 16'shffff, 1'b1, 0);
    send_item(dhd_pkg::FUNC_CAND, 16'sd0, 16'sd1, 1'b1, 0);
    send_item(dhd_pkg::FUNC_CLEAR, 16'sd0, 16'sd0, 1'b0, 0);

    // Receiver holds off while short paths keep coming.
    for (int i = 0; i < 3; i++)
      send_item(dhd_pkg::FUNC_ADD, rand_coord(), rand_coord(), 1'b0, 0);
    hold_req = 1'b1;
    for (int i = 0; i < 8; i++)
      send_item(dhd_pkg::FUNC_CAND, rand_coord(), rand_coord(), 1'b1, 0);
    send_item(dhd_pkg::FUNC_CLEAR, 16'sd0, 16'sd0, 1'b0, 0);

    // Random part: occasional reference loads, odd items, and mostly paths near the set.
    cx = rand_coord();
    cy = rand_coord();
    while (work_items < 140) begin
      r = $urandom_range(0, 99);
      if (r < 20 || (tracker.stored == 0 && r < 85)) begin
        send_item(dhd_pkg::FUNC_CLEAR, rand_coord(), rand_coord(), 1'($urandom),
                  next_gap());
        cx = rand_coord();
        cy = rand_coord();
        k  = $urandom_range(1, 12);
        for (int i = 0; i < k; i++) begin
          if ($urandom_range(0, 3) == 0)
            send_item(dhd_pkg::FUNC_ADD, rand_coord(), rand_coord(), 1'($urandom),
                      next_gap());
          else
            send_item(dhd_pkg::FUNC_ADD, near_coord(cx), near_coord(cy), 1'b0,
                      next_gap());
        end
      end else if (r < 27) begin
        case ($urandom_range(0, 2))
          0: send_item(FUNC_NOP, rand_coord(), rand_coord(), 1'($urandom), next_gap());
          1: send_item(dhd_pkg::FUNC_ADD, rand_coord(), rand_coord(), 1'($urandom),
                       next_gap());
          default: begin
            send_item(dhd_pkg::FUNC_CAND, rand_coord(), rand_coord(), 1'b0, next_gap());
            send_item(dhd_pkg::FUNC_CLEAR, 16'sd0, 16'sd0, 1'b0, next_gap());
          end
        endcase
      end else begin
        k = $urandom_range(1, 4);
        for (int i = 0; i < k; i++) begin
          if ($urandom_range(0, 4) == 0)
            send_item(dhd_pkg::FUNC_CAND, rand_coord(), rand_coord(), 1'(i == k - 1),
                      next_gap());
          else
            send_item(dhd_pkg::FUNC_CAND, near_coord(cx), near_coord(cy),
                      1'(i == k - 1), next_gap());
        end
      end
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/dhd_pkg.sv
rtl/dhd_ref_store.sv
rtl/dhd_nearest.sv
rtl/dhd_sqrt.sv
rtl/directed_hausdorff_distance.sv
bench/tb.sv
